// File: rtl/tert_pkg.sv
// Shared types and constants of the timed error report table.
package tert_pkg;

	localparam int ENTRIES  = 8;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 16;

	typedef enum logic [2:0] {
		ACT_REGISTER = 3'd0,
		ACT_CLEAR    = 3'd1,
		ACT_EXISTS   = 3'd2,
		ACT_EMPTY    = 3'd3,
		ACT_POLL     = 3'd4
	} tert_act_t;

	typedef enum logic [2:0] {
		WR_NONE   = 3'd0,
		WR_CLEAR  = 3'd1,
		WR_STAMP  = 3'd2,
		WR_REARM  = 3'd3,
		WR_INSERT = 3'd4
	} tert_wr_op_t;

	typedef struct packed {
		logic        valid;
		logic        pending;
		logic [7:0]  code;
		logic        level;
		logic [31:0] start;
		logic [31:0] interval;
	} tert_entry_t;

	typedef struct packed {
		tert_wr_op_t      op;
		logic [IDX_W-1:0] idx;
		logic [7:0]       code;
		logic [31:0]      interval;
		logic             level;
		logic [31:0]      now;
	} tert_wr_t;

	typedef struct packed {
		logic code_eq;
		logic overdue;
	} tert_cmp_t;

endpackage

// File: rtl/tert_table.sv
// Entry storage of the error table with one read port and one write port.
module tert_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [tert_pkg::IDX_W-1:0] rd_idx,
	output tert_pkg::tert_entry_t     rd,
	input  tert_pkg::tert_wr_t        wr
);

	logic        valid_q    [tert_pkg::ENTRIES];
	logic        pending_q  [tert_pkg::ENTRIES];
	logic [7:0]  code_q     [tert_pkg::ENTRIES];
	logic        level_q    [tert_pkg::ENTRIES];
	logic [31:0] start_q    [tert_pkg::ENTRIES];
	logic [31:0] interval_q [tert_pkg::ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tert_pkg::ENTRIES; i++) begin
				valid_q[i]   <= 1'b0;
				pending_q[i] <= 1'b0;
			end
		end else begin
			case (wr.op)
				tert_pkg::WR_CLEAR: valid_q[wr.idx] <= 1'b0;
				tert_pkg::WR_STAMP: pending_q[wr.idx] <= 1'b0;
				tert_pkg::WR_REARM: pending_q[wr.idx] <= 1'b1;
				tert_pkg::WR_INSERT: begin
					valid_q[wr.idx]   <= 1'b1;
					pending_q[wr.idx] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (wr.op)
			tert_pkg::WR_STAMP: start_q[wr.idx] <= wr.now;
			tert_pkg::WR_REARM: begin
				start_q[wr.idx] <= 32'd0;
				level_q[wr.idx] <= wr.level;
			end
			tert_pkg::WR_INSERT: begin
				code_q[wr.idx]     <= wr.code;
				interval_q[wr.idx] <= wr.interval;
				start_q[wr.idx]    <= 32'd0;
				level_q[wr.idx]    <= wr.level;
			end
			default: ;
		endcase
	end

	assign rd.valid    = valid_q[rd_idx];
	assign rd.pending  = pending_q[rd_idx];
	assign rd.code     = code_q[rd_idx];
	assign rd.level    = level_q[rd_idx];
	assign rd.start    = start_q[rd_idx];
	assign rd.interval = interval_q[rd_idx];

endmodule

// File: rtl/tert_cmp.sv
// Shared compare unit: code match and elapsed-time check for one entry.
module tert_cmp (
	input  logic [7:0]            key_code,
	input  logic [31:0]           now,
	input  tert_pkg::tert_entry_t ent,
	output tert_pkg::tert_cmp_t   res
);

	logic [31:0] elapsed;

	assign elapsed     = now - ent.start;
	assign res.overdue = elapsed > ent.interval;
	assign res.code_eq = ent.code == key_code;

endmodule

// File: rtl/tert_ctrl.sv
// Sequencer: scans one entry per cycle unless a poll stalls; drives result register.
module tert_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tert_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [2:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tert_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast,
	output logic [tert_pkg::IDX_W-1:0]    rd_idx,
	input  tert_pkg::tert_entry_t         rd,
	input  tert_pkg::tert_cmp_t           cmp,
	output logic [7:0]                    key_code,
	output logic [31:0]                   now,
	output tert_pkg::tert_wr_t            wr
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	localparam logic [tert_pkg::IDX_W-1:0] LAST_IDX = tert_pkg::IDX_W'(tert_pkg::ENTRIES - 1);

	state_t                    state_q;
	tert_pkg::tert_act_t       act_q;
	logic                      reject_q;
	logic [7:0]                code_q;
	logic [31:0]               intv_q;
	logic                      lvl_q;
	logic [31:0]               now_q;
	logic [tert_pkg::IDX_W-1:0] idx_q;
	logic [tert_pkg::IDX_W-1:0] fidx_q;
	logic [tert_pkg::IDX_W-1:0] ins_q;
	logic                      found_q;
	logic                      due_q;
	logic                      any_q;
	logic                      ovalid_q;
	logic                      status_q;
	logic                      fv_q;
	logic [7:0]                fcode_q;
	logic                      last_q;

	logic out_free;
	logic out_load;
	logic match;
	logic fire;
	logic step;
	logic done_status;

	assign out_free = !ovalid_q || m_tready;
	assign match    = rd.valid && cmp.code_eq;
	assign fire     = rd.valid && (rd.pending || (rd.level && cmp.overdue));
	assign step     = !(act_q == tert_pkg::ACT_POLL && fire && !out_free);
	assign out_load = (state_q == ST_SCAN && act_q == tert_pkg::ACT_POLL && fire && out_free)
		|| (state_q == ST_DONE && out_free);

	assign s_tready = state_q == ST_IDLE;
	assign rd_idx   = idx_q;
	assign key_code = code_q;
	assign now      = now_q;

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {7'd0, fcode_q, status_q};
	assign m_tuser  = fv_q;
	assign m_tlast  = last_q;

	always_comb begin
		case (act_q)
			tert_pkg::ACT_REGISTER: done_status = reject_q;
			tert_pkg::ACT_CLEAR:    done_status = 1'b0;
			tert_pkg::ACT_EXISTS:   done_status = !found_q;
			tert_pkg::ACT_EMPTY:    done_status = any_q;
			tert_pkg::ACT_POLL:     done_status = 1'b0;
			default:                done_status = 1'b1;
		endcase
	end

	always_comb begin
		wr.op       = tert_pkg::WR_NONE;
		wr.idx      = idx_q;
		wr.code     = code_q;
		wr.interval = intv_q;
		wr.level    = lvl_q;
		wr.now      = now_q;
		case (state_q)
			ST_SCAN: begin
				if (act_q == tert_pkg::ACT_CLEAR && match) begin
					wr.op = tert_pkg::WR_CLEAR;
				end else if (act_q == tert_pkg::ACT_POLL && fire && out_free) begin
					wr.op = tert_pkg::WR_STAMP;
				end
			end
			ST_WRITE: begin
				if (found_q) begin
					wr.idx = fidx_q;
					if (due_q) begin
						wr.op = tert_pkg::WR_REARM;
					end
				end else begin
					wr.idx = ins_q;
					wr.op  = tert_pkg::WR_INSERT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			idx_q    <= '0;
			ins_q    <= '0;
			found_q  <= 1'b0;
			any_q    <= 1'b0;
			reject_q <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q    <= '0;
						found_q  <= 1'b0;
						any_q    <= 1'b0;
						reject_q <= s_tdata[41];
						if ((tert_pkg::tert_act_t'(s_tuser) == tert_pkg::ACT_REGISTER
								&& s_tdata[41]) || s_tuser > 3'(tert_pkg::ACT_POLL)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (match && !found_q) begin
						found_q <= 1'b1;
					end
					if (rd.valid) begin
						any_q <= 1'b1;
					end
					if (step) begin
						if (idx_q == LAST_IDX) begin
							state_q <= (act_q == tert_pkg::ACT_REGISTER) ? ST_WRITE : ST_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_WRITE: begin
					if (!found_q) begin
						ins_q <= (ins_q == LAST_IDX) ? '0 : ins_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			act_q  <= tert_pkg::tert_act_t'(s_tuser);
			code_q <= s_tdata[7:0];
			intv_q <= s_tdata[39:8];
			lvl_q  <= s_tdata[40];
			now_q  <= s_tdata[73:42];
		end
		if (state_q == ST_SCAN && match && !found_q) begin
			fidx_q <= idx_q;
			due_q  <= cmp.overdue;
		end
		if (state_q == ST_SCAN && act_q == tert_pkg::ACT_POLL && fire && out_free) begin
			status_q <= 1'b0;
			fv_q     <= 1'b1;
			fcode_q  <= rd.code;
			last_q   <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			status_q <= done_status;
			fv_q     <= 1'b0;
			fcode_q  <= 8'd0;
			last_q   <= 1'b1;
		end
	end

endmodule

// File: rtl/timed_error_report_table_unit.sv
// Top level of the timed error report table.
//
// One request enters on the s_ channel: s_tuser holds the action (register,
// clear, exists query, empty query, poll) and s_tdata the code, interval,
// level and current tick count. Results leave on the m_ channel, one per
// handshake; m_tlast marks the final result of a request.
// The sequencer walks the table one entry per cycle, unless a poll waits on
// the output register, through a single elapsed-time and code compare unit.
// An accepted request is scanned over every entry, goes through a write
// step for register, and then closes in the done state; a rejected
// register or an unknown action goes straight to the done state. s_tready
// is high only while no request is being worked on.
// When the receiver stalls, the result register holds its value and a poll
// scan stops at the next firing entry until the register frees up.
// Reset empties the table, clears every pending mark and sets the insert
// slot to zero; stored codes, levels and times are rewritten before use.
module timed_error_report_table_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// error_code, interval_ticks, report_level, reject, now_ticks, zero fill
	input  logic [tert_pkg::S_DATA_W-1:0] s_tdata,
	// action
	input  logic [2:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, fired_code, zero fill
	output logic [tert_pkg::M_DATA_W-1:0] m_tdata,
	// fired_valid
	output logic                          m_tuser,
	output logic                          m_tlast
);

	logic [tert_pkg::IDX_W-1:0] rd_idx;
	tert_pkg::tert_entry_t      rd;
	tert_pkg::tert_cmp_t        cmp;
	tert_pkg::tert_wr_t         wr;
	logic [7:0]                 key_code;
	logic [31:0]                now;

	tert_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd     (rd),
		.wr     (wr)
	);

	tert_cmp u_cmp (
		.key_code (key_code),
		.now      (now),
		.ent      (rd),
		.res      (cmp)
	);

	tert_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.rd_idx   (rd_idx),
		.rd       (rd),
		.cmp      (cmp),
		.key_code (key_code),
		.now      (now),
		.wr       (wr)
	);

endmodule

// File: rtl/tert_checker.sv
// Port checker for the timed error report table and its bind statement.
module tert_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [tert_pkg::S_DATA_W-1:0] s_tdata,
	input logic [2:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tert_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("new request taken while one is in work");

	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tlast && !m_tdata[0])
		else $error("fired code result marked last or with status set");

	a_idle_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[8:1] == 8'd0)
		else $error("closing result carries a code or is not last");

endmodule

bind timed_error_report_table_unit tert_checker u_tert_checker (.*);
